>>> rtl/core/char_lcd_nibble_sequencer_defines.svh
// Assertion macros for the character LCD nibble sequencer.
// No dependencies; included by the top level, which does its own checks.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// Condition that must hold on every clock edge outside reset.
`define CLNS_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("clns invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define CLNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("clns implication violated");

`endif

>>> rtl/core/clns_pkg.sv
// Package for the character LCD nibble sequencer: word types, request modes,
// status codes, LCD command bytes and string buffer sizing. No dependencies.
package clns_pkg;

  // String buffer sizing
  localparam int unsigned StringDepth = 32;
  localparam int unsigned FifoAw      = $clog2(StringDepth);
  localparam int unsigned FifoCw      = $clog2(StringDepth + 1);

  // Request modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_SAVE   = 2'd2;
  localparam logic [1:0] MODE_SHOW   = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SLOT = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // LCD command bytes
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;
  localparam logic [7:0] CMD_HOME      = 8'h80;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;

  localparam logic [2:0] NUM_INIT_CMDS = 3'd4;
  localparam logic [2:0] MAX_SLOT      = 3'd7;

  // Input word
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_value;
    logic [3:0]  glyph_index;
    logic [63:0] glyph_rows;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic       rs_line;
    logic       en_line;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic [1:0] status;
  } out_item_t;

  // LCD pin levels
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
  } pins_t;

  // Power-up command sequence
  function automatic logic [7:0] init_cmd(logic [1:0] phase);
    logic [7:0] b;
    case (phase)
      2'd0:    b = CMD_FUNC_SET;
      2'd1:    b = CMD_DISP_ON;
      2'd2:    b = CMD_CLEAR;
      default: b = CMD_ENTRY;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer (4-bit HD44780-style bus).
// Depends on clns_pkg and char_lcd_nibble_sequencer_defines.svh.
//
// Usage:
//  Input channel (in_valid_i/in_ready_o/in_data_i) carries one request word:
//  a tick, a string character append, a glyph save or a glyph show. Only a
//  tick advances the pin sequencer; the other modes queue work.
//  Output channel (out_valid_o/out_ready_i/out_data_o) returns one word per
//  request: RS, EN and D4..D7 levels after the request, busy and status.
//  A word is processed as it passes from the input to the output register,
//  where its result is offered. One word per cycle is sustained while the
//  receiver does not stall: the two registers decouple the sides, and all
//  work for a word is one pass of next-state logic between them.
//  String characters sit in a 32-entry buffer memory with one registered read
//  port that always presents the entry at the head pointer.
//  Reset (rst_ni low) puts the block in the init state with pins low and the
//  buffer empty; no clearing pass is needed. The first ticks send the four
//  power-up commands.
//  When the receiver stalls, the result stays put, one further request is
//  held in the input register, and then in_ready_o drops.
`include "char_lcd_nibble_sequencer_defines.svh"

module char_lcd_nibble_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clns_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clns_pkg::out_item_t out_data_o
);
  import clns_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_WRITE = 3'd2,
    ST_SAVE  = 3'd3,
    ST_SHOW  = 3'd4
  } top_state_e;

  // One sub-step of a byte transfer: nibble setup, EN high, EN low, twice.
  function automatic pins_t drive_byte(pins_t cur, logic rs, logic [7:0] b,
                                       logic [2:0] step);
    pins_t p;
    p = cur;
    case (step)
      3'd1: begin
        p.rs  = rs;
        p.nib = b[7:4];
      end
      3'd4: begin
        p.rs  = rs;
        p.nib = b[3:0] & NIBBLE_MASK;
      end
      3'd2, 3'd5: p.en = 1'b1;
      3'd3, 3'd6: p.en = 1'b0;
      default: ;
    endcase
    return p;
  endfunction

  // Handshake registers
  logic      in_valid_q, out_valid_q, proc;
  in_item_t  in_q;
  out_item_t out_q, res;

  // Sequencer state
  top_state_e        top_state_q, top_state_d;
  logic [2:0]        init_phase_q, init_phase_d;
  logic [2:0]        tick_step_q, tick_step_d, step_inc;
  logic [1:0]        glyph_phase_q, glyph_phase_d;
  logic [3:0]        glyph_row_q, glyph_row_d;
  logic [2:0]        glyph_slot_q, glyph_slot_d;
  logic [63:0]       glyph_store_q, glyph_store_d;
  logic              save_pending_q, save_pending_d;
  logic              show_pending_q, show_pending_d;
  logic [FifoAw-1:0] fifo_head_q, fifo_head_d;
  logic [FifoAw-1:0] fifo_tail_q, fifo_tail_d;
  logic [FifoCw-1:0] fifo_count_q, fifo_count_d;
  pins_t             pins_q, pins_d;
  logic [1:0]        status;

  // String buffer memory
  logic [7:0]        fifo_mem [StringDepth];
  logic [7:0]        head_byte_q;
  logic              wr_en;
  logic [FifoAw-1:0] rd_addr;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;
  assign step_inc   = tick_step_q + 3'd1;

  // Next-state logic for one request word
  always_comb begin
    top_state_d    = top_state_q;
    init_phase_d   = init_phase_q;
    tick_step_d    = tick_step_q;
    glyph_phase_d  = glyph_phase_q;
    glyph_row_d    = glyph_row_q;
    glyph_slot_d   = glyph_slot_q;
    glyph_store_d  = glyph_store_q;
    save_pending_d = save_pending_q;
    show_pending_d = show_pending_q;
    fifo_head_d    = fifo_head_q;
    fifo_tail_d    = fifo_tail_q;
    fifo_count_d   = fifo_count_q;
    pins_d         = pins_q;
    status         = STATUS_OK;
    wr_en          = 1'b0;

    case (in_q.mode)
      MODE_TICK: begin
        case (top_state_q)
          ST_INIT: begin
            if (init_phase_q < NUM_INIT_CMDS) begin
              tick_step_d = step_inc;
              if (step_inc != 3'd7) begin
                pins_d = drive_byte(pins_q, 1'b0, init_cmd(init_phase_q[1:0]), step_inc);
              end else begin
                tick_step_d  = '0;
                init_phase_d = init_phase_q + 3'd1;
              end
            end else begin
              top_state_d = ST_IDLE;
              tick_step_d = '0;
            end
          end
          ST_WRITE: begin
            if (fifo_count_q == '0) begin
              top_state_d = ST_IDLE;
              tick_step_d = '0;
            end else begin
              tick_step_d = step_inc;
              if (step_inc != 3'd7) begin
                pins_d = drive_byte(pins_q, 1'b1, head_byte_q, step_inc);
              end else begin
                tick_step_d  = '0;
                fifo_head_d  = (fifo_head_q == FifoAw'(StringDepth - 1)) ? '0
                             : fifo_head_q + FifoAw'(1);
                fifo_count_d = fifo_count_q - FifoCw'(1);
              end
            end
          end
          ST_SAVE: begin
            case (glyph_phase_q)
              2'd0: begin
                tick_step_d = step_inc;
                pins_d = drive_byte(pins_q, 1'b0, CMD_CGRAM | {2'b00, glyph_slot_q, 3'b000},
                                    step_inc);
                if (step_inc >= 3'd6) begin
                  tick_step_d   = '0;
                  glyph_row_d   = '0;
                  glyph_phase_d = 2'd1;
                end
              end
              2'd1: begin
                if (!glyph_row_q[3]) begin
                  tick_step_d = step_inc;
                  pins_d = drive_byte(pins_q, 1'b1,
                                      glyph_store_q[{glyph_row_q[2:0], 3'b000} +: 8],
                                      step_inc);
                  if (step_inc >= 3'd6) begin
                    tick_step_d = '0;
                    glyph_row_d = glyph_row_q + 4'd1;
                  end
                end else begin
                  tick_step_d   = '0;
                  glyph_phase_d = 2'd2;
                end
              end
              default: begin
                tick_step_d = step_inc;
                pins_d = drive_byte(pins_q, 1'b0, CMD_HOME, step_inc);
                if (step_inc >= 3'd6) begin
                  glyph_row_d    = '0;
                  glyph_phase_d  = 2'd0;
                  save_pending_d = 1'b0;
                  top_state_d    = ST_IDLE;
                  tick_step_d    = '0;
                end
              end
            endcase
          end
          ST_SHOW: begin
            tick_step_d = step_inc;
            if (step_inc != 3'd7) begin
              pins_d = drive_byte(pins_q, 1'b1, {5'b00000, glyph_slot_q}, step_inc);
            end else begin
              show_pending_d = 1'b0;
              top_state_d    = ST_IDLE;
              tick_step_d    = '0;
            end
          end
          default: begin
            // Idle (or an unknown code): start the highest-priority job
            top_state_d = ST_IDLE;
            if (fifo_count_q != '0) begin
              top_state_d = ST_WRITE;
              tick_step_d = '0;
            end else if (save_pending_q) begin
              top_state_d = ST_SAVE;
              tick_step_d = '0;
            end else if (show_pending_q) begin
              top_state_d = ST_SHOW;
              tick_step_d = '0;
            end
          end
        endcase
      end
      MODE_APPEND: begin
        if (fifo_count_q >= FifoCw'(StringDepth)) begin
          status = STATUS_FULL;
        end else begin
          wr_en        = 1'b1;
          fifo_tail_d  = (fifo_tail_q == FifoAw'(StringDepth - 1)) ? '0
                       : fifo_tail_q + FifoAw'(1);
          fifo_count_d = fifo_count_q + FifoCw'(1);
        end
      end
      default: begin
        if (in_q.glyph_index > {1'b0, MAX_SLOT}) begin
          status = STATUS_BAD_SLOT;
        end else if (in_q.mode == MODE_SAVE) begin
          glyph_slot_d   = in_q.glyph_index[2:0];
          glyph_store_d  = in_q.glyph_rows;
          glyph_phase_d  = '0;
          glyph_row_d    = '0;
          save_pending_d = 1'b1;
          if (top_state_q == ST_SAVE) begin
            tick_step_d = '0;
          end
        end else begin
          glyph_slot_d   = in_q.glyph_index[2:0];
          show_pending_d = 1'b1;
        end
      end
    endcase
  end

  // Result word
  always_comb begin
    res.rs_line     = pins_d.rs;
    res.en_line     = pins_d.en;
    res.data_nibble = pins_d.nib;
    res.busy_res    = (top_state_d != ST_IDLE);
    res.status      = status;
  end

  // Input and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc) begin
      out_q <= res;
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_state_q    <= ST_INIT;
      init_phase_q   <= '0;
      tick_step_q    <= '0;
      glyph_phase_q  <= '0;
      glyph_row_q    <= '0;
      glyph_slot_q   <= '0;
      glyph_store_q  <= '0;
      save_pending_q <= 1'b0;
      show_pending_q <= 1'b0;
      fifo_head_q    <= '0;
      fifo_tail_q    <= '0;
      fifo_count_q   <= '0;
      pins_q         <= '0;
    end else if (proc) begin
      top_state_q    <= top_state_d;
      init_phase_q   <= init_phase_d;
      tick_step_q    <= tick_step_d;
      glyph_phase_q  <= glyph_phase_d;
      glyph_row_q    <= glyph_row_d;
      glyph_slot_q   <= glyph_slot_d;
      glyph_store_q  <= glyph_store_d;
      save_pending_q <= save_pending_d;
      show_pending_q <= show_pending_d;
      fifo_head_q    <= fifo_head_d;
      fifo_tail_q    <= fifo_tail_d;
      fifo_count_q   <= fifo_count_d;
      pins_q         <= pins_d;
    end
  end

  // String buffer: write at tail, registered read tracks the head entry.
  // A write landing on the next head address is forwarded to the read data.
  assign rd_addr = proc ? fifo_head_d : fifo_head_q;

  always_ff @(posedge clk_i) begin
    if (proc && wr_en) begin
      fifo_mem[fifo_tail_q] <= in_q.char_value;
    end
    if (proc && wr_en && (fifo_tail_q == rd_addr)) begin
      head_byte_q <= in_q.char_value;
    end else begin
      head_byte_q <= fifo_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `CLNS_ASSERT_IMPL(a_idle_step, clk_i, rst_ni, top_state_q == ST_IDLE, tick_step_q == '0)
  `CLNS_ASSERT_IMPL(a_idle_en_low, clk_i, rst_ni, top_state_q == ST_IDLE, !pins_q.en)
  `CLNS_ASSERT_IMPL(a_empty_ptrs, clk_i, rst_ni, fifo_count_q == '0, fifo_head_q == fifo_tail_q)
  `CLNS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, fifo_count_q <= FifoCw'(StringDepth))

endmodule
